>>> hdl/moyc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes, calendar tables and helpers of the minute of year converter.
package moyc_pkg;

  localparam int YearW   = 14;
  localparam int CmdW    = 2;
  localparam int MonW    = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int CountW  = 20;
  localparam int MinW    = 21;
  localparam int DaysW   = 10;
  localparam int RemW    = 11;

  localparam logic [CmdW-1:0] CMD_TO_MIN   = 2'd0;
  localparam logic [CmdW-1:0] CMD_TO_TIME  = 2'd1;
  localparam logic [CmdW-1:0] CMD_MIN_DIFF = 2'd2;
  localparam logic [CmdW-1:0] CMD_DAY_DIFF = 2'd3;

  localparam logic [YearW-1:0]  YEAR_RESET      = 14'd2026;
  localparam logic [10:0]       MIN_PER_DAY     = 11'd1440;
  localparam logic [5:0]        MIN_PER_HOUR    = 6'd60;
  localparam logic [CountW-1:0] YEAR_MIN_LEAP   = 20'd527040;
  localparam logic [CountW-1:0] YEAR_MIN_COMMON = 20'd525600;
  localparam logic [MonW-1:0]   LAST_MONTH      = 4'd12;

  // floor(x / 45) = (x * RECIP_45) >> 21 for x below 2^15
  localparam logic [15:0] RECIP_45 = 16'd46604;
  // floor(x / 15) = (x * RECIP_15) >> 14 for x below 2^9
  localparam logic [10:0] RECIP_15 = 11'd1093;
  // y divisible by 25 when (y * INV_25) mod 2^14 <= DIV25_MAX
  localparam logic [YearW-1:0] INV_25    = 14'd7209;
  localparam logic [YearW-1:0] DIV25_MAX = 14'd655;

  localparam logic [DayW-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DAY,
    ST_MIN,
    ST_DIFF,
    ST_DIV,
    ST_CHK,
    ST_SPLIT,
    ST_HOUR,
    ST_MINUTE,
    ST_MSCAN,
    ST_DONE
  } st_t;

  function automatic logic is_leap(logic [YearW-1:0] y);
    logic [2*YearW-1:0] prod;
    logic               div25;
    prod  = (2*YearW)'(y) * (2*YearW)'(INV_25);
    div25 = (prod[YearW-1:0] <= DIV25_MAX);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DayW-1:0] month_days(logic [MonW-1:0] m, logic leap);
    logic [DayW-1:0] len;
    len = '0;
    if ((m >= 4'd1) && (m <= LAST_MONTH)) begin
      len = MONTH_LEN[m - 4'd1];
    end
    if ((m == 4'd2) && leap) begin
      len = 5'd29;
    end
    return len;
  endfunction

endpackage

>>> hdl/moyc_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel carrying the calendar year.
interface moyc_cfg_if import moyc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [YearW-1:0] calendar_year;

  modport source (output valid, output calendar_year, input ready);
  modport sink (input valid, input calendar_year, output ready);
endinterface

>>> hdl/moyc_req_if.sv
`timescale 1ns / 1ps
// Request channel carrying one conversion command and its operands.
interface moyc_req_if import moyc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    command;
  logic [MonW-1:0]    month_a;
  logic [DayW-1:0]    day_a;
  logic [HourW-1:0]   hour_a;
  logic [MinuteW-1:0] minute_a;
  logic [MonW-1:0]    month_b;
  logic [DayW-1:0]    day_b;
  logic [HourW-1:0]   hour_b;
  logic [MinuteW-1:0] minute_b;
  logic [CountW-1:0]  minute_count;

  modport source (
    output valid, output command,
    output month_a, output day_a, output hour_a, output minute_a,
    output month_b, output day_b, output hour_b, output minute_b,
    output minute_count,
    input ready
  );
  modport sink (
    input valid, input command,
    input month_a, input day_a, input hour_a, input minute_a,
    input month_b, input day_b, input hour_b, input minute_b,
    input minute_count,
    output ready
  );
endinterface

>>> hdl/moyc_res_if.sv
`timescale 1ns / 1ps
// Result channel carrying one conversion result.
interface moyc_res_if import moyc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [MinW-1:0]   minutes_out;
  logic signed [DaysW-1:0]  days_out;
  logic [MonW-1:0]          month_out;
  logic [DayW-1:0]          day_out;
  logic [HourW-1:0]         hour_out;
  logic [MinuteW-1:0]       minute_out;
  logic                     valid_res;

  modport source (
    output valid, output minutes_out, output days_out, output month_out,
    output day_out, output hour_out, output minute_out, output valid_res,
    input ready
  );
  modport sink (
    input valid, input minutes_out, input days_out, input month_out,
    input day_out, input hour_out, input minute_out, input valid_res,
    output ready
  );
endinterface

>>> hdl/minute_of_year_converter.sv
`timescale 1ns / 1ps
// Minute of year converter: sequencer around one shared adder and a divide-by-1440 unit.
//
// Channel   Modport  Payload
// cfg       sink     calendar_year (14 bits), always ready
// request   sink     command, time A, time B, minute_count
// result    source   minutes_out, days_out, month_out, day_out, hour_out,
//                    minute_out, valid_res
//
// States from transaction to loaded result: command 0: scan, day, minute;
//   commands 2 and 3: scan, day, minute for B, then for A, then diff, and for 3 div;
//   command 1: check, then split, hour, minute, mscan, or done when beyond the year.
// The month scans step one month per cycle through the shared adder.
// Reset (rst, synchronous) sets the year to 2026 and empties the result register.
// The result register holds while result.ready is low; request stays stalled until
// the sequencer is idle again.
module minute_of_year_converter import moyc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  moyc_cfg_if.sink   cfg,
  moyc_req_if.sink   request,
  moyc_res_if.source result
);

  st_t state, state_next;

  logic                   leap;
  logic [CmdW-1:0]        cmd;
  logic [MonW-1:0]        mon_a, mon_b;
  logic [DayW-1:0]        dy_a, dy_b;
  logic [HourW-1:0]       hr_a, hr_b;
  logic [MinuteW-1:0]     mn_a, mn_b;
  logic [CountW-1:0]      count;
  logic                   sel_b;
  logic                   ok;
  logic                   neg;
  logic [MonW-1:0]        m;
  logic signed [MinW-1:0] acc;
  logic signed [MinW-1:0] tb;
  logic [RemW-1:0]        rem;
  logic [HourW-1:0]       hh;
  logic [MinuteW-1:0]     mm;
  logic [DaysW-1:0]       quo;

  logic                   accept;
  logic                   load;
  logic [MonW-1:0]        mon_sel;
  logic [DayW-1:0]        dy_sel;
  logic [HourW-1:0]       hr_sel;
  logic [MinuteW-1:0]     mn_sel;
  logic [DayW-1:0]        md;
  logic signed [MinW-1:0] add_a, add_b, add_sum;
  logic signed [MinW-1:0] day_min;
  logic [RemW-1:0]        hm;
  logic signed [MinW-1:0] new_min;
  logic [MinW-1:0]        mag;
  logic [CountW-6:0]      div_src;
  logic [30:0]            q_prod;
  logic [19:0]            h_prod;
  logic                   over;

  assign accept  = request.valid && request.ready;
  assign cfg.ready = 1'b1;

  assign mon_sel = sel_b ? mon_b : mon_a;
  assign dy_sel  = sel_b ? dy_b : dy_a;
  assign hr_sel  = sel_b ? hr_b : hr_a;
  assign mn_sel  = sel_b ? mn_b : mn_a;
  assign md      = month_days(m, leap);

  always_comb begin
    add_a = acc;
    add_b = '0;
    unique case (state)
      ST_SCAN:  add_b = MinW'(md);
      ST_DAY:   add_b = MinW'(dy_sel) - MinW'(1);
      ST_MSCAN: add_b = '0 - MinW'(md);
      ST_DIFF: begin
        add_a = tb;
        add_b = -acc;
      end
      default: add_b = '0;
    endcase
  end

  assign add_sum = add_a + add_b;

  assign day_min = MinW'($signed(acc[DaysW-1:0]) * $signed({1'b0, MIN_PER_DAY}));
  assign hm      = RemW'(hr_sel) * RemW'(MIN_PER_HOUR) + RemW'(mn_sel);
  assign new_min = day_min + $signed(MinW'(hm));

  assign mag     = acc[MinW-1] ? MinW'(-acc) : MinW'(acc);
  assign div_src = (state == ST_CHK) ? count[CountW-1:5] : mag[CountW-1:5];
  assign q_prod  = 31'(div_src) * 31'(RECIP_45);
  assign h_prod  = 20'(rem[RemW-1:2]) * 20'(RECIP_15);
  assign over    = count >= (leap ? YEAR_MIN_LEAP : YEAR_MIN_COMMON);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (request.valid) begin
          state_next = (request.command == CMD_TO_TIME) ? ST_CHK : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!(m < mon_sel)) begin
          state_next = ST_DAY;
        end
      end
      ST_DAY: state_next = ST_MIN;
      ST_MIN: begin
        if (cmd == CMD_TO_MIN) begin
          state_next = ST_DONE;
        end else if (sel_b) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF:   state_next = (cmd == CMD_MIN_DIFF) ? ST_DONE : ST_DIV;
      ST_DIV:    state_next = ST_DONE;
      ST_CHK:    state_next = over ? ST_DONE : ST_SPLIT;
      ST_SPLIT:  state_next = ST_HOUR;
      ST_HOUR:   state_next = ST_MINUTE;
      ST_MINUTE: state_next = ST_MSCAN;
      ST_MSCAN: begin
        if (!((m <= LAST_MONTH) && !add_sum[MinW-1])) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    request.ready = 1'b0;
    load          = 1'b0;
    unique case (state)
      ST_IDLE: request.ready = 1'b1;
      ST_DONE: load = !result.valid || result.ready;
      default: begin
        request.ready = 1'b0;
        load          = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      leap  <= is_leap(YEAR_RESET);
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        leap <= is_leap(cfg.calendar_year);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd   <= request.command;
          mon_a <= request.month_a;
          dy_a  <= request.day_a;
          hr_a  <= request.hour_a;
          mn_a  <= request.minute_a;
          mon_b <= request.month_b;
          dy_b  <= request.day_b;
          hr_b  <= request.hour_b;
          mn_b  <= request.minute_b;
          count <= request.minute_count;
          sel_b <= (request.command == CMD_MIN_DIFF) || (request.command == CMD_DAY_DIFF);
          ok    <= 1'b1;
          m     <= 4'd1;
          acc   <= '0;
        end
      end
      ST_SCAN: begin
        if (m < mon_sel) begin
          acc <= add_sum;
          m   <= m + 4'd1;
        end
      end
      ST_DAY: acc <= add_sum;
      ST_MIN: begin
        if (sel_b) begin
          tb    <= new_min;
          sel_b <= 1'b0;
          m     <= 4'd1;
          acc   <= '0;
        end else begin
          acc <= new_min;
        end
      end
      ST_DIFF: acc <= add_sum;
      ST_DIV: begin
        quo <= q_prod[30:21];
        neg <= acc[MinW-1];
      end
      ST_CHK: begin
        if (over) begin
          ok <= 1'b0;
        end else begin
          acc <= MinW'(q_prod[30:21]);
        end
      end
      ST_SPLIT:  rem <= count[RemW-1:0] - day_min[RemW-1:0];
      ST_HOUR:   hh <= h_prod[18:14];
      ST_MINUTE: begin
        mm <= MinuteW'(rem - RemW'(hh) * RemW'(MIN_PER_HOUR));
        m  <= 4'd1;
      end
      ST_MSCAN: begin
        if ((m <= LAST_MONTH) && !add_sum[MinW-1]) begin
          acc <= add_sum;
          m   <= m + 4'd1;
        end else if (m > LAST_MONTH) begin
          ok <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.minutes_out <= ((cmd == CMD_TO_MIN) || (cmd == CMD_MIN_DIFF)) ? acc : '0;
      result.days_out    <= (cmd == CMD_DAY_DIFF) ?
                            (neg ? -$signed(quo) : $signed(quo)) : '0;
      result.valid_res   <= ok;
      if ((cmd == CMD_TO_TIME) && ok) begin
        result.month_out  <= m;
        result.day_out    <= acc[DayW-1:0] + 5'd1;
        result.hour_out   <= hh;
        result.minute_out <= mm;
      end else begin
        result.month_out  <= '0;
        result.day_out    <= '0;
        result.hour_out   <= '0;
        result.minute_out <= '0;
      end
    end
  end

`ifndef SYNTH
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.valid_res |->
      (result.month_out == 0) && (result.day_out == 0) &&
      (result.hour_out == 0) && (result.minute_out == 0))
    else $error("invalid result carries nonzero time fields");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.valid_res && (result.month_out != 0) |->
      (result.month_out <= LAST_MONTH) && (result.day_out != 0))
    else $error("converted month or day out of range");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MSCAN) |-> (m <= 4'd13))
    else $error("month scan ran past the year");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("sequencer stayed idle after a transaction");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && result.valid && !result.ready |=> (state == ST_DONE))
    else $error("result dropped while output stalled");
`endif

endmodule

>>> tb/sv/tb_minute_of_year_converter.sv
`timescale 1ns / 1ps
// Self-checking testbench for the minute of year converter: directed and random conversions.
module tb_minute_of_year_converter import moyc_pkg::*; ();

  localparam int ResetYear       = 2026;
  localparam int MinutesPerDay   = 1440;
  localparam int MinutesPerHour  = 60;
  localparam int LeapYearMinutes = 527040;
  localparam int YearMinutes     = 525600;
  localparam int DaysInMonth [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int PhaseCount      = 10;
  localparam int ItemsPerPhase   = 85;
  localparam int WatchdogLimit   = 3000;
  localparam int DrainCycles     = 64;

  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic [MonW-1:0]    month_a;
    logic [DayW-1:0]    day_a;
    logic [HourW-1:0]   hour_a;
    logic [MinuteW-1:0] minute_a;
    logic [MonW-1:0]    month_b;
    logic [DayW-1:0]    day_b;
    logic [HourW-1:0]   hour_b;
    logic [MinuteW-1:0] minute_b;
    logic [CountW-1:0]  minute_count;
  } conversion_req_t;

  typedef struct packed {
    logic [MinW-1:0]    minutes_out;
    logic [DaysW-1:0]   days_out;
    logic [MonW-1:0]    month_out;
    logic [DayW-1:0]    day_out;
    logic [HourW-1:0]   hour_out;
    logic [MinuteW-1:0] minute_out;
    logic               valid_res;
  } conversion_res_t;

  class calendar_scoreboard;
    bit [YearW-1:0]  year;
    conversion_res_t pending_conversions [$];
    int              mismatches;
    int              checked;
    int              beyond_year;

    function new();
      year = YearW'(ResetYear);
    endfunction

    function bit leap_year(bit [YearW-1:0] y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int month_length(int m);
      if ((m < 1) || (m > 12)) return 0;
      if ((m == 2) && leap_year(year)) return 29;
      return DaysInMonth[m-1];
    endfunction

    function int minute_of_year(logic [MonW-1:0] mo, logic [DayW-1:0] d,
                                logic [HourW-1:0] h, logic [MinuteW-1:0] mi);
      int total_days;
      total_days = 0;
      for (int m = 1; m < int'(mo); m++) total_days += month_length(m);
      total_days += int'(d) - 1;
      return total_days * MinutesPerDay + int'(h) * MinutesPerHour + int'(mi);
    endfunction

    function void add_conversion(conversion_req_t r);
      conversion_res_t e;
      int span;
      int whole_days;
      int left_over;
      int m;
      int diff;
      e = '0;
      e.valid_res = 1'b1;
      case (r.command)
        CMD_TO_MIN: begin
          e.minutes_out = MinW'(minute_of_year(r.month_a, r.day_a, r.hour_a, r.minute_a));
        end
        CMD_TO_TIME: begin
          span = leap_year(year) ? LeapYearMinutes : YearMinutes;
          if (int'(r.minute_count) >= span) begin
            e.valid_res = 1'b0;
          end else begin
            whole_days = int'(r.minute_count) / MinutesPerDay;
            left_over  = int'(r.minute_count) % MinutesPerDay;
            m = 1;
            while ((m <= 12) && (whole_days >= month_length(m))) begin
              whole_days -= month_length(m);
              m++;
            end
            if (m > 12) begin
              e.valid_res = 1'b0;
            end else begin
              e.month_out  = MonW'(m);
              e.day_out    = DayW'(whole_days + 1);
              e.hour_out   = HourW'(left_over / MinutesPerHour);
              e.minute_out = MinuteW'(left_over % MinutesPerHour);
            end
          end
        end
        default: begin
          diff = minute_of_year(r.month_b, r.day_b, r.hour_b, r.minute_b)
               - minute_of_year(r.month_a, r.day_a, r.hour_a, r.minute_a);
          if (r.command == CMD_MIN_DIFF) begin
            e.minutes_out = MinW'(diff);
          end else begin
            e.days_out = DaysW'(diff / MinutesPerDay);
          end
        end
      endcase
      if (!e.valid_res) beyond_year++;
      pending_conversions.push_back(e);
    endfunction

    function void compare_field(string name, logic signed [31:0] exp_v,
                                logic signed [31:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_result(conversion_res_t got);
      conversion_res_t e;
      if (pending_conversions.size() == 0) begin
        $error("result transaction with no conversion outstanding");
        mismatches++;
        return;
      end
      e = pending_conversions.pop_front();
      checked++;
      compare_field("minutes_out", $signed(e.minutes_out), $signed(got.minutes_out));
      compare_field("days_out", $signed(e.days_out), $signed(got.days_out));
      compare_field("month_out", e.month_out, got.month_out);
      compare_field("day_out", e.day_out, got.day_out);
      compare_field("hour_out", e.hour_out, got.hour_out);
      compare_field("minute_out", e.minute_out, got.minute_out);
      compare_field("valid_res", e.valid_res, got.valid_res);
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady_flow;
  int   idle_cycles;

  calendar_scoreboard board = new();

  moyc_cfg_if cfg_ch ();
  moyc_req_if req_ch ();
  moyc_res_if res_ch ();

  minute_of_year_converter dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .request (req_ch),
    .result  (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic conversion_req_t raw_request();
    logic [63:0] bits;
    conversion_req_t r;
    bits = {$urandom, $urandom};
    r = bits[$bits(conversion_req_t)-1:0];
    return r;
  endfunction

  task automatic send_request(conversion_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.command      <= r.command;
    req_ch.month_a      <= r.month_a;
    req_ch.day_a        <= r.day_a;
    req_ch.hour_a       <= r.hour_a;
    req_ch.minute_a     <= r.minute_a;
    req_ch.month_b      <= r.month_b;
    req_ch.day_b        <= r.day_b;
    req_ch.hour_b       <= r.hour_b;
    req_ch.minute_b     <= r.minute_b;
    req_ch.minute_count <= r.minute_count;
    do @(negedge clk); while (req_ch.ready !== 1'b1);
    board.add_conversion(r);
    @(posedge clk);
  endtask

  task automatic send_times(logic [CmdW-1:0] cmd,
                            int mo_a, int d_a, int h_a, int mi_a,
                            int mo_b, int d_b, int h_b, int mi_b);
    conversion_req_t r;
    r = raw_request();
    r.command  = cmd;
    r.month_a  = MonW'(mo_a);
    r.day_a    = DayW'(d_a);
    r.hour_a   = HourW'(h_a);
    r.minute_a = MinuteW'(mi_a);
    r.month_b  = MonW'(mo_b);
    r.day_b    = DayW'(d_b);
    r.hour_b   = HourW'(h_b);
    r.minute_b = MinuteW'(mi_b);
    send_request(r);
  endtask

  task automatic send_count(int count);
    conversion_req_t r;
    r = raw_request();
    r.command      = CMD_TO_TIME;
    r.minute_count = CountW'(count);
    send_request(r);
  endtask

  task automatic send_random();
    conversion_req_t r;
    int span;
    int pick;
    r = raw_request();
    span = board.leap_year(board.year) ? LeapYearMinutes : YearMinutes;
    if ($urandom_range(0, 9) != 0) begin
      r.month_a  = MonW'($urandom_range(1, 12));
      r.day_a    = DayW'($urandom_range(1, board.month_length(r.month_a)));
      r.hour_a   = HourW'($urandom_range(0, 23));
      r.minute_a = MinuteW'($urandom_range(0, 59));
    end
    if ($urandom_range(0, 9) != 0) begin
      r.month_b  = MonW'($urandom_range(1, 12));
      r.day_b    = DayW'($urandom_range(1, board.month_length(r.month_b)));
      r.hour_b   = HourW'($urandom_range(0, 23));
      r.minute_b = MinuteW'($urandom_range(0, 59));
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      r.minute_count = CountW'($urandom_range(0, span - 1));
    end else if (pick < 7) begin
      r.minute_count = CountW'(span - 3 + $urandom_range(0, 5));
    end else if (pick < 9) begin
      // land on a month boundary, one minute either side
      r.minute_count = CountW'(board.minute_of_year(MonW'($urandom_range(1, 12)),
                                                    5'd1, 5'd0, 6'd0)
                               + $urandom_range(0, 2) - 1);
    end
    send_request(r);
  endtask

  task automatic write_year(bit [YearW-1:0] y);
    while (board.pending_conversions.size() != 0) @(posedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.calendar_year <= y;
    do @(negedge clk); while (cfg_ch.ready !== 1'b1);
    board.year = y;
    @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: random backpressure outside steady phases, check each transaction
  initial begin
    conversion_res_t got;
    int gap;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(negedge clk); while (res_ch.valid !== 1'b1);
      got.minutes_out = res_ch.minutes_out;
      got.days_out    = res_ch.days_out;
      got.month_out   = res_ch.month_out;
      got.day_out     = res_ch.day_out;
      got.hour_out    = res_ch.hour_out;
      got.minute_out  = res_ch.minute_out;
      got.valid_res   = res_ch.valid_res;
      board.check_result(got);
      @(posedge clk);
    end
  end

  initial begin
    idle_cycles = 0;
    do @(posedge clk); while (rst);
    while (idle_cycles < WatchdogLimit) begin
      @(negedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Watchdog: no transaction for %0d cycles", WatchdogLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    bit [YearW-1:0] year_plan [PhaseCount];
    year_plan = '{YearW'(ResetYear), 14'd2024, 14'd1900, 14'd2000, 14'd0, 14'd1,
                  14'd9999, 14'd16383, 14'd2100, 14'd0};
    year_plan[PhaseCount-1] = YearW'($urandom_range(0, 16383));
    steady_flow = 1'b0;
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.calendar_year <= '0;
    req_ch.valid <= 1'b0;
    {req_ch.command, req_ch.month_a, req_ch.day_a, req_ch.hour_a, req_ch.minute_a,
     req_ch.month_b, req_ch.day_b, req_ch.hour_b, req_ch.minute_b,
     req_ch.minute_count} <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // year left at its reset value for the directed part
    send_times(CMD_TO_MIN, 1, 1, 0, 0, 12, 31, 23, 59);
    send_times(CMD_TO_MIN, 12, 31, 23, 59, 1, 1, 0, 0);
    send_times(CMD_TO_MIN, 15, 31, 31, 63, 0, 0, 0, 0);
    send_times(CMD_TO_MIN, 0, 0, 0, 0, 15, 31, 31, 63);
    send_times(CMD_TO_MIN, 3, 1, 0, 0, 2, 28, 23, 59);
    send_count(0);
    send_count(YearMinutes - 1);
    send_count(YearMinutes);
    send_count(20'hFFFFF);
    send_count(59 * MinutesPerDay);
    send_count(59 * MinutesPerDay - 1);
    send_times(CMD_MIN_DIFF, 1, 1, 0, 0, 12, 31, 23, 59);
    send_times(CMD_MIN_DIFF, 12, 31, 23, 59, 1, 1, 0, 0);
    send_times(CMD_MIN_DIFF, 0, 0, 0, 0, 15, 31, 31, 63);
    send_times(CMD_MIN_DIFF, 15, 31, 31, 63, 0, 0, 0, 0);
    send_times(CMD_MIN_DIFF, 6, 15, 12, 30, 6, 15, 12, 30);
    send_times(CMD_DAY_DIFF, 1, 1, 0, 0, 12, 31, 23, 59);
    send_times(CMD_DAY_DIFF, 12, 31, 23, 59, 1, 1, 0, 0);
    send_times(CMD_DAY_DIFF, 1, 2, 0, 0, 1, 1, 23, 59);
    send_times(CMD_DAY_DIFF, 1, 3, 0, 0, 1, 1, 23, 59);
    send_times(CMD_DAY_DIFF, 0, 0, 0, 0, 15, 31, 31, 63);
    send_times(CMD_DAY_DIFF, 15, 31, 31, 63, 0, 0, 0, 0);
    send_times(CMD_DAY_DIFF, 5, 10, 8, 0, 5, 11, 7, 59);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase > 0) begin
        req_ch.valid <= 1'b0;
        write_year(year_plan[phase]);
      end
      steady_flow = (phase % 4 == 3);
      for (int n = 0; n < ItemsPerPhase; n++) send_random();
    end
    req_ch.valid <= 1'b0;
    steady_flow = 1'b0;

    while (board.pending_conversions.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Checked %0d conversions over %0d calendar year settings", board.checked,
             PhaseCount);
    $display("%0d minute counts fell beyond the end of the year", board.beyond_year);
    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
